// ----- hdl/lbhp_pkg.sv -----
// Shared types and constants for the hanging-punctuation line breaker.
package lbhp_pkg;

    localparam int POS_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ADV_W      = 32;
    localparam int CODE_W     = 16;
    localparam int PITCH_W    = 16;
    localparam int COUNT_W    = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_PITCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_KANA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_PUNCT = 3'd5;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ADV   = 2'd1;
    localparam logic [1:0] STATUS_POS_OVFL  = 2'd2;
    localparam logic [1:0] STATUS_TOO_MANY  = 2'd3;

    // Character codes and rows
    localparam logic [CODE_W-1:0] CODE_TAB        = 16'h0009;
    localparam logic [CODE_W-1:0] CODE_SPACE      = 16'h0020;
    localparam logic [CODE_W-1:0] CODE_IDEO_SPACE = 16'h2121;
    localparam logic [7:0]        ROW_PUNCT       = 8'h21;
    localparam logic [7:0]        ROW_HIRAGANA    = 8'h24;
    localparam logic [7:0]        ROW_KATAKANA    = 8'h25;
    localparam logic [CODE_W-1:0] CODE_BYTE_MAX   = 16'h00ff;

    typedef struct packed {
        logic is_tab;
        logic is_white;
        logic is_wide;
        logic may_hang;
    } char_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SUM,
        ST_CMP,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/line_break_hanging_punctuation_top.sv -----
// Top level of the hanging-punctuation line breaker.
//
// Input words on s_*: one JIS character and its advance per word; s_tuser
// flags the first character of a new text, which clears the layout state.
// Result words on m_*: one per input word, carrying the hang flag, the
// character's index in its text and the status code (sticky errors).
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per
// cycle; write only while no character is in flight.
// Path to a result: a printing character passes CHECK, SUM, CMP, DECIDE and
// DONE before m_tvalid rises; a tab also waits in DIV on the
// bit-serial remainder unit that works out pen position modulo pitch.
// Error words come out sooner: DONE follows CHECK, or CMP for a position overflow.
// One character at a time; s_tready is high only in idle, so a new character
// is taken only after the previous one has gone to the result register.
// The result register decouples the sides: a new word is accepted while
// the previous result waits on m_tready, and the block holds its next
// result until that register drains.
// Reset (aresetn low, synchronous) restores the register defaults and
// clears pen, break point, counters and error state.
module line_break_hanging_punctuation_top #(
    parameter int POS_BITS = lbhp_pkg::POS_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // char_code[15:0], char_advance[47:16]
    input  logic [0:0]  s_tuser,   // start_of_text[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // relaxed[0], char_index[32:1], status[34:33], zero
    input  logic        cfg_wr_en,
    input  logic [lbhp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbhp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int MAXW  = (POS_BITS > 32) ? POS_BITS : 32;
    localparam int SUM_W = MAXW + 1;
    localparam int PW    = lbhp_pkg::PITCH_W;
    localparam int CW    = lbhp_pkg::COUNT_W;

    // configuration
    logic [31:0]    first_width_reg;
    logic [31:0]    cont_width_reg;
    logic [PW-1:0]  pitch_reg;
    logic [CW-1:0]  max_chars_reg;
    logic           allow_kana_reg;
    logic           allow_punct_reg;

    // layout state
    lbhp_pkg::state_t state_reg, state_next;
    logic [POS_BITS-1:0] pen_reg, pen_next;
    logic [POS_BITS-1:0] break_reg, break_next;
    logic                cont_reg, cont_next;
    logic                word_reg, word_next;
    logic                permit_reg, permit_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [1:0]          err_reg, err_next;

    // per-character working registers
    logic [lbhp_pkg::CODE_W-1:0] code_reg, code_next;
    logic [lbhp_pkg::ADV_W-1:0]  adv_in_reg, adv_in_next;
    logic [CW-1:0]               index_reg, index_next;
    logic [SUM_W-1:0]            adv_reg, adv_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic                        over_reg, over_next;
    logic                        relaxed_reg, relaxed_next;

    // result register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    logic                  s_accept;
    logic                  out_free;
    logic                  start_text;
    logic [CW-1:0]         count_eff;
    logic [PW-1:0]         pitch_eff;
    logic                  div_start;
    logic                  div_done;
    logic [PW-1:0]         div_rem;
    logic                  bad_adv;
    logic                  ovfl;
    logic                  hang;
    logic                  wrap;
    logic [POS_BITS-1:0]   sum_pos;
    logic [POS_BITS-1:0]   new_pos;
    logic [31:0]           width_sel;
    lbhp_pkg::char_class_t cls;

    lbhp_class u_class (
        .code        (code_reg),
        .allow_kana  (allow_kana_reg),
        .allow_punct (allow_punct_reg),
        .cls         (cls)
    );

    lbhp_tab_mod #(
        .POS_BITS (POS_BITS)
    ) u_tab_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (pen_reg),
        .divisor   (pitch_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign s_tready   = (state_reg == lbhp_pkg::ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign start_text = s_tuser[0];
    assign count_eff  = start_text ? '0 : count_reg;
    assign pitch_eff  = (pitch_reg == '0) ? PW'(1) : pitch_reg;
    assign bad_adv    = !cls.is_tab && ((adv_in_reg == '0) || adv_in_reg[lbhp_pkg::ADV_W-1]);
    assign ovfl       = |sum_reg[SUM_W-1:POS_BITS];
    assign sum_pos    = sum_reg[POS_BITS-1:0];
    assign width_sel  = cont_reg ? cont_width_reg : first_width_reg;
    assign hang       = over_reg && permit_reg && cls.may_hang;
    assign wrap       = !hang && over_reg && (break_reg != '0);
    assign new_pos    = wrap ? (sum_pos - break_reg) : sum_pos;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lbhp_pkg::ST_IDLE: begin
                if (s_accept) state_next = lbhp_pkg::ST_CHECK;
            end
            lbhp_pkg::ST_CHECK: begin
                if (err_reg != lbhp_pkg::STATUS_OK || index_reg >= max_chars_reg || bad_adv) begin
                    state_next = lbhp_pkg::ST_DONE;
                end else if (cls.is_tab) begin
                    state_next = lbhp_pkg::ST_DIV;
                end else begin
                    state_next = lbhp_pkg::ST_SUM;
                end
            end
            lbhp_pkg::ST_DIV: begin
                if (div_done) state_next = lbhp_pkg::ST_SUM;
            end
            lbhp_pkg::ST_SUM: begin
                state_next = lbhp_pkg::ST_CMP;
            end
            lbhp_pkg::ST_CMP: begin
                state_next = ovfl ? lbhp_pkg::ST_DONE : lbhp_pkg::ST_DECIDE;
            end
            lbhp_pkg::ST_DECIDE: begin
                state_next = lbhp_pkg::ST_DONE;
            end
            lbhp_pkg::ST_DONE: begin
                if (out_free) state_next = lbhp_pkg::ST_IDLE;
            end
            default: state_next = lbhp_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        pen_next      = pen_reg;
        break_next    = break_reg;
        cont_next     = cont_reg;
        word_next     = word_reg;
        permit_next   = permit_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        code_next     = code_reg;
        adv_in_next   = adv_in_reg;
        index_next    = index_reg;
        adv_next      = adv_reg;
        sum_next      = sum_reg;
        over_next     = over_reg;
        relaxed_next  = relaxed_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;
        case (state_reg)
            lbhp_pkg::ST_IDLE: begin
                if (s_accept) begin
                    code_next    = s_tdata[15:0];
                    adv_in_next  = s_tdata[47:16];
                    index_next   = count_eff;
                    count_next   = (count_eff == '1) ? count_eff : count_eff + 1'b1;
                    relaxed_next = 1'b0;
                    if (start_text) begin
                        pen_next    = '0;
                        break_next  = '0;
                        cont_next   = 1'b0;
                        word_next   = 1'b0;
                        permit_next = 1'b1;
                        err_next    = lbhp_pkg::STATUS_OK;
                    end
                end
            end
            lbhp_pkg::ST_CHECK: begin
                if (err_reg == lbhp_pkg::STATUS_OK) begin
                    if (index_reg >= max_chars_reg) begin
                        err_next = lbhp_pkg::STATUS_TOO_MANY;
                    end else if (bad_adv) begin
                        err_next = lbhp_pkg::STATUS_BAD_ADV;
                    end else if (cls.is_tab) begin
                        div_start = 1'b1;
                    end else begin
                        adv_next = {{(SUM_W-lbhp_pkg::ADV_W){1'b0}}, adv_in_reg};
                    end
                end
            end
            lbhp_pkg::ST_DIV: begin
                adv_next = {{(SUM_W-PW){1'b0}}, pitch_eff - div_rem};
            end
            lbhp_pkg::ST_SUM: begin
                sum_next = {{(SUM_W-POS_BITS){1'b0}}, pen_reg} + adv_reg;
            end
            lbhp_pkg::ST_CMP: begin
                if (ovfl) begin
                    err_next = lbhp_pkg::STATUS_POS_OVFL;
                end
                over_next = (sum_reg > {{(SUM_W-32){1'b0}}, width_sel}) && !cls.is_white;
            end
            lbhp_pkg::ST_DECIDE: begin
                if (hang) begin
                    permit_next  = 1'b0;
                    relaxed_next = 1'b1;
                end else if (wrap) begin
                    permit_next = 1'b1;
                    cont_next   = 1'b1;
                end
                if (cls.is_wide || cls.is_white) begin
                    word_next  = 1'b0;
                    break_next = new_pos;
                end else if (!word_reg) begin
                    // ASCII word starts: break before it
                    word_next  = 1'b1;
                    break_next = pen_reg;
                end
                pen_next = new_pos;
            end
            lbhp_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, err_reg, index_reg, relaxed_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_width_reg <= 32'd1;
            cont_width_reg  <= 32'd1;
            pitch_reg       <= PW'(1);
            max_chars_reg   <= '1;
            allow_kana_reg  <= 1'b0;
            allow_punct_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lbhp_pkg::CFG_FIRST_WIDTH: first_width_reg <= cfg_wdata;
                lbhp_pkg::CFG_CONT_WIDTH:  cont_width_reg  <= cfg_wdata;
                lbhp_pkg::CFG_TAB_PITCH:   pitch_reg       <= cfg_wdata[PW-1:0];
                lbhp_pkg::CFG_MAX_CHARS:   max_chars_reg   <= cfg_wdata;
                lbhp_pkg::CFG_ALLOW_KANA:  allow_kana_reg  <= cfg_wdata[0];
                lbhp_pkg::CFG_ALLOW_PUNCT: allow_punct_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lbhp_pkg::ST_IDLE;
            pen_reg      <= '0;
            break_reg    <= '0;
            cont_reg     <= 1'b0;
            word_reg     <= 1'b0;
            permit_reg   <= 1'b1;
            count_reg    <= '0;
            err_reg      <= lbhp_pkg::STATUS_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pen_reg      <= pen_next;
            break_reg    <= break_next;
            cont_reg     <= cont_next;
            word_reg     <= word_next;
            permit_reg   <= permit_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        code_reg    <= code_next;
        adv_in_reg  <= adv_in_next;
        index_reg   <= index_next;
        adv_reg     <= adv_next;
        sum_reg     <= sum_next;
        over_reg    <= over_next;
        relaxed_reg <= relaxed_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted while a character was in flight");

    a_hang_clears_permit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lbhp_pkg::ST_DECIDE && hang) |=> !permit_reg && relaxed_reg)
        else $error("hang did not consume the relaxation permit");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lbhp_pkg::ST_CHECK && err_reg != lbhp_pkg::STATUS_OK)
        |=> err_reg == $past(err_reg))
        else $error("sticky error changed without start of text");

    a_relaxed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tdata[34:33] == lbhp_pkg::STATUS_OK)
        else $error("relaxed result carries an error status");

endmodule

// ----- hdl/lbhp_tab_mod.sv -----
// Bit-serial remainder unit: pen position modulo the tab pitch.
module lbhp_tab_mod #(
    parameter int POS_BITS = lbhp_pkg::POS_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [POS_BITS-1:0]          dividend,
    input  logic [lbhp_pkg::PITCH_W-1:0] divisor,
    output logic                         done,
    output logic [lbhp_pkg::PITCH_W-1:0] remainder
);

    localparam int CNT_W = $clog2(POS_BITS + 1);
    localparam int PW    = lbhp_pkg::PITCH_W;

    logic [POS_BITS-1:0] shift_reg, shift_next;
    logic [PW-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [PW:0]         trial;

    // one dividend bit per cycle, MSB first
    assign trial = {rem_reg, shift_reg[POS_BITS-1]};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CNT_W'(POS_BITS);
            run_next   = 1'b1;
        end else if (run_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = PW'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[PW-1:0];
            end
            shift_next = {shift_reg[POS_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/lbhp_class.sv -----
// Character classifier: spaces, tab, wide codes and hangable marks.
module lbhp_class (
    input  logic [lbhp_pkg::CODE_W-1:0] code,
    input  logic                        allow_kana,
    input  logic                        allow_punct,
    output lbhp_pkg::char_class_t       cls
);

    logic [7:0] row;
    logic [7:0] low_byte;
    logic       kana_hit;
    logic       punct_hit;

    assign row      = code[15:8];
    assign low_byte = code[7:0];

    always_comb begin
        kana_hit  = 1'b0;
        punct_hit = 1'b0;
        if (row == lbhp_pkg::ROW_HIRAGANA || row == lbhp_pkg::ROW_KATAKANA) begin
            kana_hit = low_byte inside {8'h21, 8'h23, 8'h25, 8'h27, 8'h29,
                                        8'h43, 8'h63, 8'h65, 8'h67};
        end
        if (row == lbhp_pkg::ROW_PUNCT) begin
            punct_hit = low_byte inside {8'h22, 8'h23, 8'h4b, 8'h57, 8'h59};
        end
    end

    assign cls.is_tab   = (code == lbhp_pkg::CODE_TAB);
    assign cls.is_white = (code == lbhp_pkg::CODE_TAB) || (code == lbhp_pkg::CODE_SPACE)
                          || (code == lbhp_pkg::CODE_IDEO_SPACE);
    assign cls.is_wide  = (code > lbhp_pkg::CODE_BYTE_MAX);
    assign cls.may_hang = (allow_kana && kana_hit) || (allow_punct && punct_hit);

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the hanging-punctuation line breaker.
`timescale 1ns / 1ps

module testbench;
    import lbhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] SMALL_KANA_CELLS [9] =
        '{8'h21, 8'h23, 8'h25, 8'h27, 8'h29, 8'h43, 8'h63, 8'h65, 8'h67};
    localparam logic [7:0] HANG_PUNCT_CELLS [5] = '{8'h22, 8'h23, 8'h4b, 8'h57, 8'h59};

    typedef struct {
        logic        relaxed;
        logic [31:0] index;
        logic [1:0]  status;
    } char_result_t;

    // Layout predictor plus the queue of results it has promised.
    class layout_scoreboard;
        logic [31:0] first_width, cont_width, max_chars;
        logic [15:0] tab_pitch;
        logic        allow_kana, allow_punct;
        logic [31:0] pen, brk, char_count;
        logic        on_cont, in_word, permit;
        logic [1:0]  err;
        char_result_t pending_results[$];
        int errors, checked, hung, flagged;

        function new();
            first_width = 1;
            cont_width  = 1;
            tab_pitch   = 1;
            max_chars   = '1;
            allow_kana  = 0;
            allow_punct = 0;
            errors = 0;
            checked = 0;
            hung = 0;
            flagged = 0;
            clear_text();
        endfunction

        function void clear_text();
            pen = 0;
            brk = 0;
            on_cont = 0;
            in_word = 0;
            permit = 1;
            char_count = 0;
            err = STATUS_OK;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_FIRST_WIDTH: first_width = val;
                CFG_CONT_WIDTH:  cont_width  = val;
                CFG_TAB_PITCH:   tab_pitch   = val[15:0];
                CFG_MAX_CHARS:   max_chars   = val;
                CFG_ALLOW_KANA:  allow_kana  = val[0];
                CFG_ALLOW_PUNCT: allow_punct = val[0];
                default: ;
            endcase
        endfunction

        function bit is_blank(logic [15:0] code);
            return code == CODE_SPACE || code == CODE_TAB || code == CODE_IDEO_SPACE;
        endfunction

        function bit hangable(logic [15:0] code);
            if (allow_kana && (code[15:8] == ROW_HIRAGANA || code[15:8] == ROW_KATAKANA)) begin
                foreach (SMALL_KANA_CELLS[i])
                    if (code[7:0] == SMALL_KANA_CELLS[i]) return 1;
            end
            if (allow_punct && code[15:8] == ROW_PUNCT) begin
                foreach (HANG_PUNCT_CELLS[i])
                    if (code[7:0] == HANG_PUNCT_CELLS[i]) return 1;
            end
            return 0;
        endfunction

        function void note_input(logic [15:0] code, logic [31:0] adv, logic start);
            char_result_t r;
            logic [32:0]  next_pen;
            logic [32:0]  step;
            logic [31:0]  width;
            logic [31:0]  pitch;
            bit           over;
            if (start) clear_text();
            r.relaxed = 0;
            r.index = char_count;
            if (char_count != '1) char_count++;
            if (err == STATUS_OK) begin
                width = on_cont ? cont_width : first_width;
                if (r.index >= max_chars) begin
                    err = STATUS_TOO_MANY;
                end else if (code != CODE_TAB && (adv == 0 || adv[31])) begin
                    err = STATUS_BAD_ADV;
                end else begin
                    if (code == CODE_TAB) begin
                        pitch = (tab_pitch == 0) ? 32'd1 : {16'd0, tab_pitch};
                        step = {1'b0, pitch - (pen % pitch)};
                    end else begin
                        step = {1'b0, adv};
                    end
                    next_pen = {1'b0, pen} + step;
                    if (next_pen[32]) begin
                        err = STATUS_POS_OVFL;
                    end else begin
                        over = next_pen > {1'b0, width} && !is_blank(code);
                        if (over && permit && hangable(code)) begin
                            permit = 0;
                            r.relaxed = 1;
                        end else if (over && brk != 0) begin
                            permit = 1;
                            on_cont = 1;
                            next_pen = next_pen - {1'b0, brk};
                        end
                        if (code > CODE_BYTE_MAX || is_blank(code)) begin
                            in_word = 0;
                            brk = next_pen[31:0];
                        end else if (!in_word) begin
                            // ASCII word starts: break before it
                            in_word = 1;
                            brk = pen;
                        end
                        pen = next_pen[31:0];
                    end
                end
            end
            r.status = err;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_result(logic [39:0] word);
            char_result_t r;
            checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, word);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            if (word[0]) hung++;
            if (word[34:33] != STATUS_OK) flagged++;
            if (word[0] !== r.relaxed) begin
                $display("%0t: relaxed mismatch: expected %0d, got %0d", $time, r.relaxed, word[0]);
                errors++;
            end
            if (word[32:1] !== r.index) begin
                $display("%0t: char_index mismatch: expected %0d, got %0d",
                         $time, r.index, word[32:1]);
                errors++;
            end
            if (word[34:33] !== r.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, r.status, word[34:33]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    layout_scoreboard sb = new();
    bit quiet = 1'b0;     // no gaps or stalls while set
    int chars_sent = 0;
    int settings_used = 0;

    line_break_hanging_punctuation_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_char(input logic [15:0] code, input logic [31:0] adv,
                             input logic start);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {adv, code};
        s_tuser  <= start;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_input(code, adv, start);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [31:0] fw, input logic [31:0] cw,
                                input logic [31:0] pitch, input logic [31:0] maxc,
                                input logic kana, input logic punct);
        write_reg(CFG_FIRST_WIDTH, fw);
        write_reg(CFG_CONT_WIDTH, cw);
        write_reg(CFG_TAB_PITCH, pitch);
        write_reg(CFG_MAX_CHARS, maxc);
        write_reg(CFG_ALLOW_KANA, {31'd0, kana});
        write_reg(CFG_ALLOW_PUNCT, {31'd0, punct});
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_code();
        int k;
        k = $urandom_range(0, 99);
        if (k < 35) return {8'h00, 8'($urandom_range(8'h21, 8'h7e))};
        if (k < 45) return CODE_SPACE;
        if (k < 50) return CODE_TAB;
        if (k < 55) return CODE_IDEO_SPACE;
        if (k < 68) return {($urandom_range(0, 1) ? ROW_KATAKANA : ROW_HIRAGANA),
                            SMALL_KANA_CELLS[$urandom_range(0, 8)]};
        if (k < 78) return {ROW_PUNCT, HANG_PUNCT_CELLS[$urandom_range(0, 4)]};
        if (k < 90) return {($urandom_range(0, 1) ? ROW_KATAKANA : ROW_HIRAGANA),
                            8'($urandom_range(8'h21, 8'h76))};
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_advance(input logic [31:0] adv_max);
        int k;
        k = $urandom_range(0, 99);
        if (k < 1) return 32'd0;
        if (k < 2) return {1'b1, 31'($urandom)};
        if (k < 3) return $urandom_range(32'h7fff_ffff, 32'h4000_0000);
        return $urandom_range(adv_max, 1);
    endfunction

    // Mostly well-formed texts with random content, some raw noise words.
    task automatic run_texts(input int n_items, input logic [31:0] adv_max);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(3, 30);
            for (int i = 0; i < len && sent < n_items; i++) begin
                if ($urandom_range(0, 99) < 8)
                    send_char(16'($urandom), $urandom, 1'($urandom_range(0, 1)));
                else
                    send_char(pick_code(), pick_advance(adv_max), i == 0);
                sent++;
            end
        end
    endtask

    // Result side: random stall before each word.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata);
            @(negedge aclk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: hang, wrap, tab, spaces, sticky errors, overflow
        program_regs(32'd10, 32'd12, 32'd4, 32'hffff_ffff, 1'b1, 1'b1);
        send_char(16'h0041, 32'd3, 1'b1);
        send_char(16'h0042, 32'd3, 1'b0);
        send_char(CODE_SPACE, 32'd2, 1'b0);
        send_char(16'h2421, 32'd4, 1'b0);        // small kana hangs
        send_char(16'h2422, 32'd4, 1'b0);        // wraps at the break point
        send_char(16'h2122, 32'd3, 1'b0);
        send_char(CODE_TAB, 32'd0, 1'b0);
        send_char(CODE_IDEO_SPACE, 32'd5, 1'b0);
        send_char(16'h2123, 32'd2, 1'b0);        // punctuation hangs
        send_char(16'h0000, 32'd1, 1'b0);
        send_char(16'hffff, 32'h7fff_ffff, 1'b0);
        send_char(16'h0041, 32'd0, 1'b0);        // zero advance
        send_char(16'h0041, 32'd5, 1'b0);        // error stays
        send_char(16'h0041, 32'h8000_0000, 1'b1);
        send_char(16'h0061, 32'h7fff_ffff, 1'b1);
        send_char(16'h0061, 32'h7fff_ffff, 1'b0);
        send_char(16'h0061, 32'd2, 1'b0);        // pen passes 2^32-1
        send_char(CODE_SPACE, 32'd1, 1'b0);
        send_char(16'h0041, 32'd1, 1'b1);
        send_char(CODE_TAB, 32'h8000_0000, 1'b0); // tab ignores its advance
        wait_drained();

        // zero widths and zero pitch, tiny character limit
        program_regs(32'd0, 32'd0, 32'd0, 32'd3, 1'b0, 1'b0);
        send_char(CODE_TAB, 32'd7, 1'b1);
        send_char(16'h2421, 32'd1, 1'b0);
        send_char(16'h2122, 32'd1, 1'b0);
        send_char(16'h0041, 32'd1, 1'b0);        // over the limit
        send_char(16'h0041, 32'd1, 1'b1);
        wait_drained();

        program_regs(32'd40, 32'd60, 32'd8, 32'hffff_ffff, 1'b1, 1'b1);
        run_texts(160, 32'd8);
        wait_drained();

        quiet = 1'b1;
        program_regs(32'd1, 32'd1, 32'd1, 32'hffff_ffff, 1'b1, 1'b0);
        run_texts(120, 32'd3);
        wait_drained();
        quiet = 1'b0;

        program_regs(32'hffff_ffff, 32'hffff_ffff, 32'd65535, 32'hffff_ffff, 1'b0, 1'b1);
        run_texts(100, 32'h4000_0000);
        wait_drained();

        program_regs($urandom_range(10, 200), $urandom_range(10, 200),
                     $urandom_range(1, 20), 32'd15, 1'b1, 1'b1);
        run_texts(140, 32'd10);
        wait_drained();

        quiet = 1'($urandom_range(0, 1));
        program_regs($urandom_range(1, 500), $urandom_range(1, 500),
                     $urandom_range(1, 65535), $urandom,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_texts(140, 32'd30);
        wait_drained();
        quiet = 1'b0;

        program_regs(32'd30, 32'd30, 32'd65535, 32'hffff_ffff, 1'b1, 1'b1);
        run_texts(140, 32'd6);
        wait_drained();

        repeat (60) @(posedge aclk);
        $display("Sent %0d characters under %0d register settings; %0d results checked.",
                 chars_sent, settings_used, sb.checked);
        $display("Results with a hang into the margin: %0d; with an error status: %0d.",
                 sb.hung, sb.flagged);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
